/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every sampled edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tlp_pkg.sv */
`timescale 1ns / 1ps

package tlp_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int CFG_DATA_W          = 16;
    localparam int CFG_INDEX_W         = 3;
    localparam int LEN_W               = 16;
    localparam int REP_W               = 4;
    localparam int LAMP_W              = 6;

    localparam int LAMP_CG = 0;
    localparam int LAMP_CY = 1;
    localparam int LAMP_CR = 2;
    localparam int LAMP_PG = 3;
    localparam int LAMP_PY = 4;
    localparam int LAMP_PR = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_STEADY_HOLD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAR_YEL_ON   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAR_YEL_OFF  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PED_YEL_ON   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PED_YEL_OFF  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_REPS   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_WALK         = 3'd6;

    typedef enum logic [2:0] {
        PH_GREEN        = 3'd0,
        PH_YELLOW       = 3'd1,
        PH_RED          = 3'd2,
        PH_JOINT_YELLOW = 3'd3,
        PH_WALK         = 3'd4,
        PH_WALK_END     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        PREV_GREEN = 2'd0,
        PREV_NONE  = 2'd1,
        PREV_RED   = 2'd2
    } prev_steady_t;

    typedef enum logic [1:0] {
        STEP_ON_FIRST = 2'd0,
        STEP_OFF      = 2'd1,
        STEP_ON_LAST  = 2'd2
    } blink_step_t;

    typedef struct packed {
        logic [LEN_W-1:0] steady_hold;
        logic [LEN_W-1:0] car_on;
        logic [LEN_W-1:0] car_off;
        logic [LEN_W-1:0] ped_on;
        logic [LEN_W-1:0] ped_off;
        logic [REP_W-1:0] repeats;
        logic [LEN_W-1:0] walk;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        steady_hold: 16'd3400,
        car_on:      16'd380,
        car_off:     16'd180,
        ped_on:      16'd390,
        ped_off:     16'd190,
        repeats:     4'd5,
        walk:        16'd5000
    };

    typedef struct packed {
        phase_t            phase;
        prev_steady_t      prev_steady;
        logic              ped_request;
        logic [REP_W-1:0]  repeat_count;
        blink_step_t       blink_step;
        logic [LAMP_W-1:0] lamps;
    } ctrl_state_t;

    localparam ctrl_state_t STATE_RESET = '{
        phase:        PH_GREEN,
        prev_steady:  PREV_NONE,
        ped_request:  1'b0,
        repeat_count: '0,
        blink_step:   STEP_ON_FIRST,
        lamps:        '0
    };

    typedef struct packed {
        logic       car_green;
        logic       car_yellow;
        logic       car_red;
        logic       ped_green;
        logic       ped_yellow;
        logic       ped_red;
        logic [2:0] phase_code;
    } result_t;

endpackage

/* rtl/tlp_if.sv */
`timescale 1ns / 1ps

interface tlp_in_if;
    logic valid;
    logic ready;
    logic button_press;

    modport source (output valid, output button_press, input ready);
    modport sink   (input valid, input button_press, output ready);
endinterface

interface tlp_out_if;
    logic       valid;
    logic       ready;
    logic       car_green;
    logic       car_yellow;
    logic       car_red;
    logic       ped_green;
    logic       ped_yellow;
    logic       ped_red;
    logic [2:0] phase_code;

    modport source (
        output valid, output car_green, output car_yellow, output car_red,
        output ped_green, output ped_yellow, output ped_red, output phase_code,
        input ready
    );
    modport sink (
        input valid, input car_green, input car_yellow, input car_red,
        input ped_green, input ped_yellow, input ped_red, input phase_code,
        output ready
    );
endinterface

/* rtl/tlp_step.sv */
`timescale 1ns / 1ps

module tlp_step #(
    parameter int COUNT_WIDTH = tlp_pkg::COUNT_WIDTH_DEFAULT
) (
    input  tlp_pkg::ctrl_state_t   cur,
    input  logic [COUNT_WIDTH-1:0] tick_cur,
    input  tlp_pkg::cfg_t          cfg,
    input  logic                   button_press,
    output tlp_pkg::ctrl_state_t   nxt,
    output logic [COUNT_WIDTH-1:0] tick_nxt,
    output tlp_pkg::result_t       res
);
    import tlp_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
    localparam logic [CMP_W-1:0] CMAX = CMP_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    logic [LEN_W-1:0]       len_sel;
    logic [CMP_W-1:0]       lim;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic                   seg_done;
    logic [REP_W-1:0]       rep_need;

    always_comb
    begin
        unique case (cur.phase)
            PH_GREEN, PH_RED:
                len_sel = cfg.steady_hold;
            PH_YELLOW:
                len_sel = (cur.blink_step == STEP_OFF) ? cfg.car_off : cfg.car_on;
            PH_JOINT_YELLOW, PH_WALK_END:
                len_sel = (cur.blink_step == STEP_OFF) ? cfg.ped_off : cfg.ped_on;
            PH_WALK:
                len_sel = cfg.walk;
            default:
                len_sel = cfg.steady_hold;
        endcase
    end

    always_comb
    begin
        lim = CMP_W'(len_sel);
        if (lim == '0)
        begin
            lim = CMP_W'(1);
        end
        if (lim > CMAX)
        begin
            lim = CMAX;
        end
        tick_inc = tick_cur + COUNT_WIDTH'(1);
        seg_done = CMP_W'(tick_inc) >= lim;
        rep_need = (cfg.repeats == '0) ? REP_W'(1) : cfg.repeats;
    end

    always_comb
    begin
        ctrl_state_t st;
        logic [COUNT_WIDTH-1:0] tk;
        logic rep_end;
        logic reps_done;

        st        = cur;
        tk        = tick_cur;
        rep_end   = 1'b0;
        reps_done = 1'b0;

        if ((cur.phase == PH_GREEN || cur.phase == PH_YELLOW || cur.phase == PH_RED)
            && button_press)
        begin
            st.ped_request = 1'b1;
        end

        // lamps shown during this tick
        unique case (cur.phase)
            PH_GREEN:
            begin
                st.lamps[LAMP_PG] = 1'b0;
                st.lamps[LAMP_PY] = 1'b0;
                st.lamps[LAMP_CY] = 1'b0;
                st.lamps[LAMP_CR] = 1'b0;
                st.lamps[LAMP_CG] = 1'b1;
            end
            PH_YELLOW:
            begin
                st.lamps[LAMP_PG] = 1'b0;
                st.lamps[LAMP_PY] = 1'b0;
                st.lamps[LAMP_CY] = (cur.blink_step != STEP_OFF);
            end
            PH_RED:
            begin
                st.lamps[LAMP_PG] = 1'b0;
                st.lamps[LAMP_PY] = 1'b0;
                st.lamps[LAMP_CG] = 1'b0;
                st.lamps[LAMP_CY] = 1'b0;
                st.lamps[LAMP_CR] = 1'b1;
            end
            PH_JOINT_YELLOW:
            begin
                st.lamps[LAMP_PG] = 1'b0;
                st.lamps[LAMP_PR] = 1'b1;
                st.lamps[LAMP_CY] = (cur.blink_step != STEP_OFF);
                st.lamps[LAMP_PY] = (cur.blink_step != STEP_OFF);
            end
            PH_WALK:
            begin
                st.lamps[LAMP_PY] = 1'b0;
                st.lamps[LAMP_PR] = 1'b0;
                st.lamps[LAMP_CG] = 1'b0;
                st.lamps[LAMP_CY] = 1'b0;
                st.lamps[LAMP_PG] = 1'b1;
                st.lamps[LAMP_CR] = 1'b1;
            end
            PH_WALK_END:
            begin
                st.lamps[LAMP_CR] = 1'b0;
                st.lamps[LAMP_CY] = (cur.blink_step != STEP_OFF);
                st.lamps[LAMP_PY] = (cur.blink_step != STEP_OFF);
            end
            default:
            begin
                st.lamps = cur.lamps;
            end
        endcase

        res.car_green  = st.lamps[LAMP_CG];
        res.car_yellow = st.lamps[LAMP_CY];
        res.car_red    = st.lamps[LAMP_CR];
        res.ped_green  = st.lamps[LAMP_PG];
        res.ped_yellow = st.lamps[LAMP_PY];
        res.ped_red    = st.lamps[LAMP_PR];
        res.phase_code = cur.phase;

        // segment counter, shared by all timed phases
        if (cur.phase == PH_GREEN || cur.phase == PH_YELLOW || cur.phase == PH_RED
            || cur.phase == PH_JOINT_YELLOW || cur.phase == PH_WALK
            || cur.phase == PH_WALK_END)
        begin
            tk = seg_done ? '0 : tick_inc;
        end

        // blink sequencing
        if ((cur.phase == PH_YELLOW || cur.phase == PH_JOINT_YELLOW
             || cur.phase == PH_WALK_END) && seg_done)
        begin
            if (cur.blink_step == STEP_ON_FIRST)
            begin
                st.blink_step = STEP_OFF;
            end
            else if (cur.blink_step == STEP_OFF)
            begin
                st.blink_step = STEP_ON_LAST;
            end
            else
            begin
                st.blink_step   = STEP_ON_FIRST;
                st.repeat_count = cur.repeat_count + REP_W'(1);
                rep_end         = 1'b1;
            end
        end
        reps_done = st.repeat_count >= rep_need;

        unique case (cur.phase)
            PH_GREEN:
            begin
                if (st.ped_request)
                begin
                    st.phase       = PH_JOINT_YELLOW;
                    st.prev_steady = PREV_NONE;
                end
                else if (seg_done)
                begin
                    st.phase       = PH_YELLOW;
                    st.prev_steady = PREV_GREEN;
                end
            end
            PH_YELLOW:
            begin
                if (rep_end && (st.ped_request || reps_done))
                begin
                    st.lamps[LAMP_CY] = 1'b0;
                    st.lamps[LAMP_PY] = 1'b0;
                    if (st.ped_request)
                    begin
                        st.phase = PH_JOINT_YELLOW;
                    end
                    else
                    begin
                        st.phase = (cur.prev_steady == PREV_RED) ? PH_GREEN : PH_RED;
                    end
                    st.prev_steady = PREV_NONE;
                end
            end
            PH_RED:
            begin
                if (st.ped_request)
                begin
                    st.phase       = PH_WALK;
                    st.prev_steady = PREV_NONE;
                end
                else if (seg_done)
                begin
                    st.phase       = PH_YELLOW;
                    st.prev_steady = PREV_RED;
                end
            end
            PH_JOINT_YELLOW:
            begin
                if (rep_end && reps_done)
                begin
                    st.lamps[LAMP_CY] = 1'b0;
                    st.lamps[LAMP_PY] = 1'b0;
                    st.lamps[LAMP_CR] = 1'b1;
                    st.phase          = PH_WALK;
                    st.prev_steady    = PREV_NONE;
                end
            end
            PH_WALK:
            begin
                if (seg_done)
                begin
                    st.lamps[LAMP_CR] = 1'b0;
                    st.phase          = PH_WALK_END;
                end
            end
            PH_WALK_END:
            begin
                if (rep_end && reps_done)
                begin
                    st.lamps[LAMP_CY] = 1'b0;
                    st.lamps[LAMP_PY] = 1'b0;
                    st.lamps[LAMP_PR] = 1'b1;
                    st.ped_request    = 1'b0;
                    st.phase          = PH_GREEN;
                    st.prev_steady    = PREV_NONE;
                end
            end
            default:
            begin
                st.phase       = PH_RED;
                st.prev_steady = PREV_NONE;
            end
        endcase

        // restart counters on every phase change, and on the stray-code fallback
        if (st.phase != cur.phase || !(cur.phase == PH_GREEN || cur.phase == PH_YELLOW
            || cur.phase == PH_RED || cur.phase == PH_JOINT_YELLOW
            || cur.phase == PH_WALK || cur.phase == PH_WALK_END))
        begin
            tk              = '0;
            st.repeat_count = '0;
            st.blink_step   = STEP_ON_FIRST;
        end

        nxt      = st;
        tick_nxt = tk;
    end

endmodule

/* rtl/tlp_out_buf.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlp_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  tlp_pkg::result_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output tlp_pkg::result_t pop_data
);
    import tlp_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_data_reg;
    result_t skid_data_reg;
    logic    push;
    logic    pop;

    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = main_valid_reg && pop_ready;
    assign pop_valid  = main_valid_reg;
    assign pop_data   = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!main_valid_reg || pop)
            begin
                main_valid_reg <= skid_valid_reg || push;
                skid_valid_reg <= 1'b0;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    `ASSERT_IMPLIES(a_skid_behind_main, clk, rst_n, skid_valid_reg, main_valid_reg, "skid full with main empty")
    `ASSERT_NEXT(a_stalled_beat_to_skid, clk, rst_n, push && main_valid_reg && !pop_ready, skid_valid_reg, "stalled beat lost")

endmodule

/* rtl/traffic_light_ped_controller.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Dir  Handshake      Payload
// tick_in   in   valid/ready    button_press
// lamp_out  out  valid/ready    six lamp bits, phase_code
// cfg       in   cfg_wr_en      cfg_index, cfg_data (no read-back)
//
// One tick beat per clock while tick_in is ready: the state registers update in the cycle of the beat.
// Each lamp beat is registered in a two-entry output buffer, in the skid entry if lamp_out stalls.
// A stalled lamp_out keeps tick_in ready for one more beat, then holds it off.
// Reset: phase green, no request, all lamps off, registers at their defaults.

module traffic_light_ped_controller #(
    parameter int COUNT_WIDTH = tlp_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tlp_in_if.sink                          tick_in,
    tlp_out_if.source                       lamp_out,
    input  logic                            cfg_wr_en,
    input  logic [tlp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tlp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tlp_pkg::*;

    cfg_t                   cfg_reg;
    ctrl_state_t            state_reg;
    ctrl_state_t            state_next;
    logic [COUNT_WIDTH-1:0] tick_reg;
    logic [COUNT_WIDTH-1:0] tick_next;
    result_t                step_res;
    result_t                out_res;
    logic                   tick_ready;
    logic                   tick_acc;

    assign tick_in.ready = tick_ready;
    assign tick_acc      = tick_in.valid && tick_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_STEADY_HOLD: cfg_reg.steady_hold <= cfg_data;
                CFG_CAR_YEL_ON:  cfg_reg.car_on      <= cfg_data;
                CFG_CAR_YEL_OFF: cfg_reg.car_off     <= cfg_data;
                CFG_PED_YEL_ON:  cfg_reg.ped_on      <= cfg_data;
                CFG_PED_YEL_OFF: cfg_reg.ped_off     <= cfg_data;
                CFG_BLINK_REPS:  cfg_reg.repeats     <= cfg_data[REP_W-1:0];
                CFG_WALK:        cfg_reg.walk        <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    tlp_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .cur          (state_reg),
        .tick_cur     (tick_reg),
        .cfg          (cfg_reg),
        .button_press (tick_in.button_press),
        .nxt          (state_next),
        .tick_nxt     (tick_next),
        .res          (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
            tick_reg  <= '0;
        end
        else if (tick_acc)
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
        end
    end

    tlp_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (tick_in.valid),
        .push_ready (tick_ready),
        .push_data  (step_res),
        .pop_valid  (lamp_out.valid),
        .pop_ready  (lamp_out.ready),
        .pop_data   (out_res)
    );

    assign lamp_out.car_green  = out_res.car_green;
    assign lamp_out.car_yellow = out_res.car_yellow;
    assign lamp_out.car_red    = out_res.car_red;
    assign lamp_out.ped_green  = out_res.ped_green;
    assign lamp_out.ped_yellow = out_res.ped_yellow;
    assign lamp_out.ped_red    = out_res.ped_red;
    assign lamp_out.phase_code = out_res.phase_code;

    `ASSERT_IMPLIES(a_off_step_in_yellow, clk, rst_n, state_reg.blink_step == STEP_OFF, state_reg.phase == PH_YELLOW || state_reg.phase == PH_JOINT_YELLOW || state_reg.phase == PH_WALK_END, "off step outside a yellow phase")
    `ASSERT_IMPLIES(a_ped_seq_has_request, clk, rst_n, state_reg.phase == PH_JOINT_YELLOW || state_reg.phase == PH_WALK || state_reg.phase == PH_WALK_END, state_reg.ped_request, "pedestrian sequence without request")
    `ASSERT_IMPLIES(a_request_clears_at_end, clk, rst_n, $fell(state_reg.ped_request), $past(state_reg.phase) == PH_WALK_END, "request dropped early")

endmodule
